[src/rbs_pkg.sv]
// Package of the range bucket scatter unit: beat types, register codes, reset values.
package rbs_pkg;

  localparam int MAX_SHARDS_DEF = 8;
  localparam int SHARD_W        = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHARD_TOTAL    = 3'd0,
    CFG_LOW_BIT        = 3'd1,
    CFG_HIGH_BIT       = 3'd2,
    CFG_WIDE_MODE      = 3'd3,
    CFG_SHARD_CAPACITY = 3'd4
  } cfg_idx_e;

  localparam logic [3:0]  SHARD_TOTAL_RST    = 4'd1;
  localparam logic [5:0]  LOW_BIT_RST        = 6'd0;
  localparam logic [6:0]  HIGH_BIT_RST       = 7'd32;
  localparam logic        WIDE_MODE_RST      = 1'b0;
  localparam logic [31:0] SHARD_CAPACITY_RST = 32'hFFFF_FFFF;

  localparam logic KIND_ITEM   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [63:0] sort_key;
    logic [31:0] payload;
    logic        end_of_run;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [SHARD_W-1:0] shard;
    logic [31:0]        slot_or_total;
    logic [63:0]        out_key;
    logic [31:0]        out_payload;
    logic               over_capacity;
    logic               final_result;
  } out_item_t;

endpackage

[src/range_bucket_scatter_unit.sv]
// Top level of the range bucket scatter unit: sequencer, shard fill memory, output register.
//
// Usage: keys enter on the in_* valid/ready channel, one beat per key with its
// payload and an end_of_run flag. Each key leaves on the out_* channel as one
// placed-item beat carrying its shard and its slot (the shard's fill count
// before this key). A key flagged end_of_run is followed by one report beat
// per active shard (shard 0 upward) giving the shard's total; the last beat
// of each key carries final_result. The fill counters are then cleared.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// After a key is accepted, the sequencer multiplies its field by the active
// shard count, reads the fill memory and then loads the item beat into the
// output register at its update step; no new key is accepted until the last
// is through. An end-of-run key adds a read and an emit step per active shard.
// Reset clears all fill counters at once through per-shard valid bits and
// loads the register defaults. When the receiver stalls, the output register
// holds its beat and the sequencer waits at its emit step; one further key
// may still be accepted and worked up to that step.
module range_bucket_scatter_unit #(
  parameter int MAX_SHARDS = rbs_pkg::MAX_SHARDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rbs_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rbs_pkg::out_item_t              out_item_o
);

  localparam int IdxW   = $clog2(MAX_SHARDS);
  localparam int CntW   = $clog2(MAX_SHARDS + 1);
  localparam int ProdW  = 32 + CntW;
  localparam int ShardW = rbs_pkg::SHARD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RD,
    S_UPD,
    S_REP_RD,
    S_REP_OUT
  } state_e;

  // ---------------- configuration registers ----------------
  logic [3:0]  shard_total_q;
  logic [5:0]  low_bit_q;
  logic [6:0]  high_bit_q;
  logic        wide_mode_q;
  logic [31:0] capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shard_total_q <= rbs_pkg::SHARD_TOTAL_RST;
      low_bit_q     <= rbs_pkg::LOW_BIT_RST;
      high_bit_q    <= rbs_pkg::HIGH_BIT_RST;
      wide_mode_q   <= rbs_pkg::WIDE_MODE_RST;
      capacity_q    <= rbs_pkg::SHARD_CAPACITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbs_pkg::CFG_SHARD_TOTAL:    shard_total_q <= cfg_data_i[3:0];
        rbs_pkg::CFG_LOW_BIT:        low_bit_q     <= cfg_data_i[5:0];
        rbs_pkg::CFG_HIGH_BIT:       high_bit_q    <= cfg_data_i[6:0];
        rbs_pkg::CFG_WIDE_MODE:      wide_mode_q   <= cfg_data_i[0];
        rbs_pkg::CFG_SHARD_CAPACITY: capacity_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Active shard count: zero acts as one, clamp at MAX_SHARDS.
  logic [CntW-1:0] n_act;
  always_comb begin
    if (shard_total_q == 4'd0) begin
      n_act = CntW'(1);
    end else if (32'(shard_total_q) > 32'(MAX_SHARDS)) begin
      n_act = CntW'(MAX_SHARDS);
    end else begin
      n_act = CntW'(shard_total_q);
    end
  end

  // ---------------- field extraction at accept ----------------
  // Field [lo, hi) of the key; fields wider than 32 bits keep width-32 bits from bit hi-32.
  logic [6:0]  top_bit, hi_lim, lo_ext, fld_w;
  logic        fld_empty, fld_wide;
  logic [5:0]  fld_sh, fld_bits;
  logic [63:0] key_m, key_sh;
  logic [32:0] fld_mask;
  logic [31:0] fld_val;
  logic [31:0] pay_m;

  always_comb begin
    top_bit   = wide_mode_q ? 7'd64 : 7'd32;
    hi_lim    = (high_bit_q > top_bit) ? top_bit : high_bit_q;
    lo_ext    = {1'b0, low_bit_q};
    fld_empty = (hi_lim <= lo_ext);
    fld_w     = hi_lim - lo_ext;
    fld_wide  = (fld_w > 7'd32);
    fld_sh    = fld_wide ? 6'(hi_lim - 7'd32) : low_bit_q;
    fld_bits  = fld_empty ? 6'd1 : (fld_wide ? 6'(fld_w - 7'd32) : 6'(fld_w));
    key_m     = wide_mode_q ? in_item_i.sort_key : {32'd0, in_item_i.sort_key[31:0]};
    pay_m     = wide_mode_q ? 32'd0 : in_item_i.payload;
    key_sh    = key_m >> fld_sh;
    fld_mask  = (33'd1 << fld_bits) - 33'd1;
    fld_val   = fld_empty ? 32'd0 : (key_sh[31:0] & fld_mask[31:0]);
  end

  // ---------------- shard fill memory ----------------
  logic [31:0]           fill_mem [MAX_SHARDS];
  logic [31:0]           rdata_q;
  logic                  mem_re, mem_we;
  logic [IdxW-1:0]       mem_raddr, mem_waddr;
  logic [31:0]           mem_wdata;
  logic [MAX_SHARDS-1:0] fill_vld_q;   // cleared entries read as zero

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fill_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= fill_mem[mem_raddr];
    end
  end

  // ---------------- sequencer ----------------
  state_e           state_q;
  logic [63:0]      key_q;
  logic [31:0]      pay_q;
  logic             last_q;
  logic [31:0]      val_q;
  logic [5:0]       bits_q;
  logic [ProdW-1:0] prod_q;
  logic [IdxW-1:0]  d_q;
  logic [CntW-1:0]  rep_idx_q;
  logic             out_valid_q, out_valid_d;
  rbs_pkg::out_item_t out_q;

  logic             out_free, in_fire;
  logic [ProdW-1:0] prod_sh;
  logic [IdxW-1:0]  d_calc;
  logic [31:0]      slot_cur, slot_inc, rep_total;
  logic             rep_last, item_load, rep_load;

  always_comb begin
    out_free  = !out_valid_q || out_ready_i;
    in_fire   = in_valid_i && in_ready_o;
    prod_sh   = prod_q >> bits_q;
    d_calc    = (prod_sh >= ProdW'(MAX_SHARDS)) ? IdxW'(MAX_SHARDS - 1) : prod_sh[IdxW-1:0];
    slot_cur  = fill_vld_q[d_q] ? rdata_q : 32'd0;
    slot_inc  = (slot_cur == 32'hFFFF_FFFF) ? slot_cur : slot_cur + 32'd1;
    rep_total = fill_vld_q[rep_idx_q[IdxW-1:0]] ? rdata_q : 32'd0;
    rep_last  = (rep_idx_q == n_act - CntW'(1));
    item_load = (state_q == S_UPD) && out_free;
    rep_load  = (state_q == S_REP_OUT) && out_free;

    // output beat: a new load wins, else it drops once taken
    out_valid_d = out_valid_q && !out_ready_i;
    if (item_load || rep_load) begin
      out_valid_d = 1'b1;
    end

    mem_re    = (state_q == S_RD) || (state_q == S_REP_RD);
    mem_raddr = (state_q == S_RD) ? d_calc : rep_idx_q[IdxW-1:0];
    mem_we    = item_load;
    mem_waddr = d_q;
    mem_wdata = slot_inc;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_vld_q  <= '0;
      out_valid_q <= 1'b0;
      rep_idx_q   <= '0;
      key_q       <= '0;
      pay_q       <= '0;
      last_q      <= 1'b0;
      val_q       <= '0;
      bits_q      <= '0;
      prod_q      <= '0;
      d_q         <= '0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            key_q   <= key_m;
            pay_q   <= pay_m;
            last_q  <= in_item_i.end_of_run;
            val_q   <= fld_val;
            bits_q  <= fld_bits;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= ProdW'(val_q) * ProdW'(n_act);
          state_q <= S_RD;
        end
        S_RD: begin
          d_q     <= d_calc;
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (item_load) begin
            fill_vld_q[d_q]     <= 1'b1;
            out_q.kind          <= rbs_pkg::KIND_ITEM;
            out_q.shard         <= ShardW'(d_q);
            out_q.slot_or_total <= slot_cur;
            out_q.out_key       <= key_q;
            out_q.out_payload   <= pay_q;
            out_q.over_capacity <= (slot_cur >= capacity_q);
            out_q.final_result  <= !last_q;
            rep_idx_q           <= '0;
            state_q             <= last_q ? S_REP_RD : S_IDLE;
          end
        end
        S_REP_RD: begin
          state_q <= S_REP_OUT;
        end
        S_REP_OUT: begin
          if (rep_load) begin
            out_q.kind          <= rbs_pkg::KIND_REPORT;
            out_q.shard         <= ShardW'(rep_idx_q);
            out_q.slot_or_total <= rep_total;
            out_q.out_key       <= 64'd0;
            out_q.out_payload   <= 32'd0;
            out_q.over_capacity <= (rep_total > capacity_q);
            out_q.final_result  <= rep_last;
            if (rep_last) begin
              // end of run: every counter, reported or not, restarts at zero
              fill_vld_q <= '0;
              state_q    <= S_IDLE;
            end else begin
              rep_idx_q <= rep_idx_q + CntW'(1);
              state_q   <= S_REP_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_shard_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (32'(d_q) < 32'(n_act)))
    else $error("placed shard outside active shard range");

  a_clear_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_load && rep_last) |=> (fill_vld_q == '0))
    else $error("fill counters not cleared at end of run");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second key accepted while one is in flight");

endmodule
